FILE: design/sm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_pkg: shared types and constants
// Initial value, round constants and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam int WordW = 32;
    localparam int BlockWords = 16;
    localparam int Rounds = 64;

    localparam logic [WordW-1:0] TjLow  = 32'h79cc4519;
    localparam logic [WordW-1:0] TjHigh = 32'h7a879d8a;
    localparam logic [WordW-1:0] OneBit = 32'h80000000;

    localparam logic [8*WordW-1:0] Iv = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    typedef enum logic [1:0] {
        WSEL_DATA = 2'b00,
        WSEL_ONE  = 2'b01,
        WSEL_ZERO = 2'b10,
        WSEL_LEN  = 2'b11
    } wsel_t;

    typedef struct packed {
        logic  push;       // write a word into the block buffer
        wsel_t wsel;
        logic  len_hi;     // which length word
        logic  add_bits;   // accumulate message length
        logic  round_go;   // run one compression round
        logic  round_init; // load working vars and schedule
        logic  fold;       // xor working vars into chaining value
        logic  reinit;     // return to IV and clear length
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] wpos;
        logic [5:0] round;
    } dp_stat_t;

    function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                              input logic [4:0] n);
        logic [2*WordW-1:0] t;
        t = {x, x} << n;
        return t[2*WordW-1:WordW];
    endfunction

    function automatic logic [WordW-1:0] p0(input logic [WordW-1:0] x);
        return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
    endfunction

    function automatic logic [WordW-1:0] p1(input logic [WordW-1:0] x);
        return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
    endfunction

endpackage
`default_nettype wire

FILE: design/sm3_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_datapath: block buffer, message schedule and compression round
// One round per cycle while round_go is asserted, over a 16-word sliding schedule window.
// ----------------------------------------------------------------------------
module sm3_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sm3_pkg::dp_cmd_t     cmd,
    input  wire logic [31:0]          in_word,
    input  wire logic [5:0]           add_len,
    output sm3_pkg::dp_stat_t         stat,
    output logic [8*32-1:0]           cv
);
    import sm3_pkg::*;

    logic [31:0] buf_reg [BlockWords];
    logic [31:0] win_reg [BlockWords];
    logic [3:0]  wpos_reg;
    logic [5:0]  round_reg;
    logic [63:0] len_reg;
    logic [8*32-1:0] cv_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;

    logic [31:0] wr_word, wnew, tj, a12, ss1, ss2, ff, gg, tt1, tt2, w0, w4;

    always_comb begin
        case (cmd.wsel)
            WSEL_DATA: wr_word = in_word;
            WSEL_ONE:  wr_word = OneBit;
            WSEL_ZERO: wr_word = '0;
            WSEL_LEN:  wr_word = cmd.len_hi ? len_reg[63:32] : len_reg[31:0];
            default:   wr_word = '0;
        endcase
    end

    always_comb begin
        w0   = win_reg[0];
        w4   = win_reg[4];
        wnew = p1(win_reg[0] ^ win_reg[7] ^ {win_reg[13][16:0], win_reg[13][31:17]})
             ^ {win_reg[3][24:0], win_reg[3][31:25]} ^ win_reg[10];
        tj   = (round_reg < 6'd16) ? TjLow : TjHigh;
        a12  = {a_reg[19:0], a_reg[31:20]};
        ss1  = rotl(a12 + e_reg + rotl(tj, round_reg[4:0]), 5'd7);
        ss2  = ss1 ^ a12;
        if (round_reg < 6'd16) begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end else begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        tt1 = ff + d_reg + ss2 + (w0 ^ w4);
        tt2 = gg + h_reg + ss1 + w0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            buf_reg[wpos_reg] <= wr_word;
        end
        if (cmd.round_init) begin
            for (int i = 0; i < BlockWords; i++) begin
                win_reg[i] <= buf_reg[i];
            end
            {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg} <= cv_reg;
        end else if (cmd.round_go) begin
            for (int i = 0; i < BlockWords - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[BlockWords-1] <= wnew;
            d_reg <= c_reg;
            c_reg <= {b_reg[22:0], b_reg[31:23]};
            b_reg <= a_reg;
            a_reg <= tt1;
            h_reg <= g_reg;
            g_reg <= {f_reg[12:0], f_reg[31:13]};
            f_reg <= e_reg;
            e_reg <= p0(tt2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg  <= '0;
            round_reg <= '0;
            len_reg   <= '0;
            cv_reg    <= Iv;
        end else begin
            if (cmd.push) begin
                wpos_reg <= wpos_reg + 4'd1;
            end
            if (cmd.round_init) begin
                round_reg <= '0;
            end else if (cmd.round_go) begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.reinit) begin
                len_reg <= '0;
                cv_reg  <= Iv;
            end else begin
                if (cmd.add_bits) begin
                    len_reg <= len_reg + {58'd0, add_len};
                end
                if (cmd.fold) begin
                    cv_reg <= cv_reg ^ {a_reg, b_reg, c_reg, d_reg,
                                        e_reg, f_reg, g_reg, h_reg};
                end
            end
        end
    end

    assign stat.wpos  = wpos_reg;
    assign stat.round = round_reg;
    assign cv = cv_reg;

endmodule
`default_nettype wire

FILE: design/sm3_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_ctrl: sequencing of word intake, padding, rounds and digest output
// ----------------------------------------------------------------------------
module sm3_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [5:0]        s_valid_bits,
    input  wire logic              s_last_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_word_index,
    output logic                   m_last_of_digest,
    output logic                   sel_masked,
    input  wire sm3_pkg::dp_stat_t stat,
    output sm3_pkg::dp_cmd_t       cmd,
    output logic [5:0]             part_bits
);
    import sm3_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ONE   = 7'b0000010,
        ST_PAD   = 7'b0000100,
        ST_INIT  = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_FOLD  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;     // message is in padding
    logic   padded_reg, padded_next; // length written: last block
    logic [2:0] idx_reg, idx_next;
    logic [5:0] vb;
    // one bit still owed after a full last word that closed a block
    logic pend_one_reg, pend_one_next;

    assign vb = (s_valid_bits > 6'd32) ? 6'd32 : s_valid_bits;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_word_index = idx_reg;
    assign m_last_of_digest = (idx_reg == 3'd7);

    always_comb begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        padded_next  = padded_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.wsel     = WSEL_DATA;
        sel_masked   = 1'b0;
        part_bits    = s_last_word ? vb : 6'd32;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.push = 1'b1;
                    cmd.add_bits = 1'b1;
                    if (!s_last_word) begin
                        if (stat.wpos == 4'd15) state_next = ST_INIT;
                    end else begin
                        fin_next = 1'b1;
                        if (vb == 6'd32) begin
                            state_next = (stat.wpos == 4'd15) ? ST_INIT : ST_ONE;
                        end else begin
                            sel_masked = 1'b1;
                            state_next = (stat.wpos == 4'd15) ? ST_INIT : ST_PAD;
                        end
                        // a full word followed by the one bit in the next block
                        if (vb == 6'd32 && stat.wpos == 4'd15) fin_next = 1'b0;
                    end
                end
            end
            ST_ONE: begin
                cmd.push = 1'b1;
                cmd.wsel = WSEL_ONE;
                fin_next = 1'b1;
                state_next = (stat.wpos == 4'd15) ? ST_INIT : ST_PAD;
            end
            ST_PAD: begin
                cmd.push = 1'b1;
                cmd.wsel = WSEL_ZERO;
                if (stat.wpos == 4'd14) begin
                    cmd.wsel = WSEL_LEN;
                    cmd.len_hi = 1'b1;
                    padded_next = 1'b1;
                end else if (stat.wpos == 4'd15) begin
                    state_next = ST_INIT;
                    if (padded_reg) begin
                        cmd.wsel = WSEL_LEN;
                    end
                end
            end
            ST_INIT: begin
                cmd.round_init = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_go = 1'b1;
                if (stat.round == 6'd63) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (padded_reg) begin
                    state_next = ST_OUT;
                    idx_next = '0;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else if (pend_one_reg) begin
                    state_next = ST_ONE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                        fin_next = 1'b0;
                        padded_next = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pend_one_next = pend_one_reg;
        if (state_reg == ST_IDLE && s_valid && s_last_word && vb == 6'd32
            && stat.wpos == 4'd15) pend_one_next = 1'b1;
        if (state_reg == ST_ONE) pend_one_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fin_reg      <= 1'b0;
            padded_reg   <= 1'b0;
            idx_reg      <= '0;
            pend_one_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fin_reg      <= fin_next;
            padded_reg   <= padded_next;
            idx_reg      <= idx_next;
            pend_one_reg <= pend_one_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/sm3_hash_bitlen_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_hash_bitlen_core: SM3 hash over bit-length messages
// A word that fills a block starts a compression (load, 64 rounds, fold);
// other words are only buffered; s_ready stays low while a block is compressed.
// The last word adds padding words, one or two compressions,
// then eight digest words at one per cycle as m_ready allows.
// Reset: synchronous active-low aresetn returns to the initial value, empty.
// ----------------------------------------------------------------------------
module sm3_hash_bitlen_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_data_word,
    input  wire logic [5:0]  s_valid_bits,
    input  wire logic        s_last_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_of_digest
);
    import sm3_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     sel_masked;
    logic [5:0] part_bits;
    logic [31:0] keep, in_word;
    logic [8*32-1:0] cv;

    sm3_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_valid_bits, .s_last_word,
        .m_valid, .m_ready, .m_word_index, .m_last_of_digest,
        .sel_masked, .stat, .cmd, .part_bits
    );

    assign keep = (part_bits == 6'd0) ? 32'd0 : (32'hFFFFFFFF << (6'd32 - part_bits));
    assign in_word = sel_masked
        ? ((s_data_word & keep) | (OneBit >> part_bits)) : s_data_word;

    sm3_datapath u_dp (
        .aclk, .aresetn, .cmd, .in_word, .add_len(part_bits), .stat, .cv
    );

    assign m_digest_word = cv[(7 - m_word_index) * 32 +: 32];

endmodule
`default_nettype wire
